// ----- rtl/core/dedup_ring_fifo_unit_defines.svh -----
// assertion macros for the dedup ring fifo unit
// no dependencies; included by the top level only
`ifndef DEDUP_RING_FIFO_UNIT_DEFINES_SVH
`define DEDUP_RING_FIFO_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define DRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dedup ring fifo check failed");

// next-cycle implication, held off during reset
`define DRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dedup ring fifo check failed");

`endif

// ----- rtl/core/drf_pkg.sv -----
// shared types and constants of the dedup ring fifo unit
// no dependencies; imported by every module of the block but drf_ram
`default_nettype none

package drf_pkg;

    // default number of record slots (holds one fewer record)
    localparam int DEPTH_DEF = 64;

    // width of the reported occupancy
    localparam int USED_W = 6;

    // action codes of an input request
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    // classified operation
    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_FLUSH,
        OP_NOP
    } t_op;

    // one arp record
    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] code;
        logic [47:0] mac;
    } t_rec;

    // classified request handed from front to back
    typedef struct packed {
        t_op  op;
        logic uniq;
        t_rec rec;
    } t_cmd;

    // one result
    typedef struct packed {
        logic              pop_valid;
        t_rec              rec;
        logic              full_seen;
        logic              push_dropped;
        logic              push_duplicate;
        logic [31:0]       overrun;
        logic [USED_W-1:0] used;
    } t_res;

endpackage

`default_nettype wire

// ----- rtl/core/drf_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module drf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/drf_front.sv -----
// front end: accepts requests, classifies the action, queues two deep
// depends on drf_pkg
`default_nettype none

module drf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [1:0]    i_action,
    input  wire logic          i_unique_only,
    input  wire drf_pkg::t_rec i_rec,
    output logic               o_full,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output drf_pkg::t_cmd      o_cmd
);

    import drf_pkg::*;

    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       r_q [2];
    t_cmd       w_cmd;
    logic       w_wr;
    logic       w_rd;

    // classify the action code
    always_comb begin
        w_cmd.rec = i_rec;
        case (i_action)
            ACT_PUSH:  w_cmd.op = OP_PUSH;
            ACT_POP:   w_cmd.op = OP_POP;
            ACT_FLUSH: w_cmd.op = OP_FLUSH;
            default:   w_cmd.op = OP_NOP;
        endcase
        w_cmd.uniq = i_unique_only && (w_cmd.op == OP_PUSH);
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = o_cmd_valid && i_cmd_ready;

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/drf_back.sv -----
// back end: ring indices, record store, duplicate scan and result build
// depends on drf_pkg and drf_ram
`default_nettype none

module drf_back #(
    parameter int DEPTH = drf_pkg::DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ring_mode,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire drf_pkg::t_cmd i_cmd,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output drf_pkg::t_res      o_res
);

    import drf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int UW = (AW + 1 > USED_W) ? AW + 1 : USED_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic        r_full_flag, n_full_flag;
    logic [31:0] r_overrun, n_overrun;
    logic [AW-1:0] r_scan, n_scan;
    logic        r_issue, n_issue;
    logic        r_pend, n_pend;
    logic        r_dup, n_dup;

    logic          w_full;
    logic          w_empty;
    logic          w_commit;
    logic          w_store;
    logic          w_drop;
    logic [AW-1:0] w_raddr;
    logic [$bits(t_rec)-1:0] w_rdata;
    t_rec          w_rrec;
    logic [AW:0]   w_diff;
    logic [UW-1:0] w_used_wide;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    // record store
    drf_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_commit && w_store && (r_cmd.op == OP_PUSH)),
        .i_waddr (r_wr_idx),
        .i_wdata (r_cmd.rec),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rrec  = t_rec'(w_rdata);
    assign w_raddr = (r_state == S_SCAN) ? r_scan : r_rd_idx;
    assign w_full  = (next_slot(r_wr_idx) == r_rd_idx);
    assign w_empty = (r_wr_idx == r_rd_idx);
    assign w_drop  = w_full && !i_ring_mode;
    assign w_store = !w_drop && !r_dup;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EXEC);
    assign w_commit    = o_res_valid && i_res_ready;

    // sequencer and execution of one request
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_full_flag = r_full_flag;
        n_overrun   = r_overrun;
        n_scan      = r_scan;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_dup       = r_dup;

        o_res.pop_valid      = 1'b0;
        o_res.rec            = '0;
        o_res.push_dropped   = 1'b0;
        o_res.push_duplicate = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    n_dup = 1'b0;
                    if (i_cmd.op == OP_PUSH && i_cmd.uniq && !w_drop && !w_empty) begin
                        n_state = S_SCAN;
                        n_scan  = r_rd_idx;
                        n_issue = 1'b1;
                        n_pend  = 1'b0;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                // one stored entry read per cycle, compared when its registered read data arrives
                if (r_issue) begin
                    n_scan  = next_slot(r_scan);
                    n_issue = (next_slot(r_scan) != r_wr_idx);
                end
                n_pend = r_issue;
                if (r_pend && (w_rrec == r_cmd.rec)) begin
                    n_dup = 1'b1;
                end
                if (!r_issue && !r_pend) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    OP_PUSH: begin
                        n_full_flag = w_full;
                        if (w_full && (r_overrun != '1)) begin
                            n_overrun = r_overrun + 32'd1;
                        end
                        o_res.push_dropped   = w_drop;
                        o_res.push_duplicate = !w_drop && r_dup;
                        if (w_store) begin
                            n_wr_idx = next_slot(r_wr_idx);
                            if (w_full) begin
                                n_rd_idx = next_slot(r_rd_idx);
                            end
                        end
                    end
                    OP_POP: begin
                        if (!w_empty) begin
                            o_res.pop_valid = 1'b1;
                            o_res.rec       = w_rrec;
                            n_rd_idx        = next_slot(r_rd_idx);
                        end
                    end
                    OP_FLUSH: begin
                        n_rd_idx    = r_wr_idx;
                        n_full_flag = 1'b0;
                    end
                    default: begin
                    end
                endcase
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end else begin
                    n_wr_idx    = r_wr_idx;
                    n_rd_idx    = r_rd_idx;
                    n_full_flag = r_full_flag;
                    n_overrun   = r_overrun;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // status after this request
        w_diff = (n_wr_idx >= n_rd_idx)
               ? ({1'b0, n_wr_idx} - {1'b0, n_rd_idx})
               : ({1'b0, n_wr_idx} + (AW + 1)'(DEPTH) - {1'b0, n_rd_idx});
        w_used_wide     = UW'(w_diff);
        o_res.full_seen = n_full_flag;
        o_res.overrun   = n_overrun;
        o_res.used      = w_used_wide[USED_W-1:0];
    end

    // state and ring registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_full_flag <= 1'b0;
            r_overrun   <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_dup       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_full_flag <= n_full_flag;
            r_overrun   <= n_overrun;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_dup       <= n_dup;
        end
        r_cmd  <= n_cmd;
        r_scan <= n_scan;
    end

endmodule

`default_nettype wire

// ----- rtl/core/dedup_ring_fifo_unit.sv -----
// Circular fifo of arp records (ip, type code, mac) with an optional
// duplicate filter, a drop or ring overflow mode and a saturating overrun
// count. Requests enter a two-deep queue (push/full) and every request gives
// one result, queued two deep (empty/pop). A pop, flush, no-op or plain push goes
// from idle straight to execution in the back end, as does a push with the
// unique flag that meets an empty fifo or is dropped; any other push with the
// unique flag first scans the occupied entries of the record store, a ram with
// one read port, one entry per cycle. ring_mode is written on the cfg channel,
// which is always ready. depends on drf_pkg, drf_front, drf_back and the
// defines header
`default_nettype none

module dedup_ring_fifo_unit #(
    parameter int DEPTH = drf_pkg::DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [1:0]                 i_action,
    input  wire logic                       i_unique_only,
    input  wire logic [31:0]                i_in_ip,
    input  wire logic [15:0]                i_in_type,
    input  wire logic [47:0]                i_in_mac,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_pop_valid,
    output logic [31:0]                     o_out_ip,
    output logic [15:0]                     o_out_type,
    output logic [47:0]                     o_out_mac,
    output logic                            o_full_seen,
    output logic                            o_push_dropped,
    output logic                            o_push_duplicate,
    output logic [31:0]                     o_overrun_count,
    output logic [drf_pkg::USED_W-1:0]      o_used_count,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic                       i_cfg_data
);

    import drf_pkg::*;

    logic       r_ring_mode;
    t_rec       w_in_rec;
    logic       w_cmd_valid;
    logic       w_cmd_ready;
    t_cmd       w_cmd;
    logic       w_res_valid;
    logic       w_res_ready;
    t_res       w_res;
    t_res       r_oq [2];
    logic       r_oq_wp;
    logic       r_oq_rp;
    logic [1:0] r_oq_cnt;
    logic       w_oq_wr;
    logic       w_oq_rd;
    t_res       w_head;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ring_mode <= i_cfg_data;
        end
    end

    assign w_in_rec.ip   = i_in_ip;
    assign w_in_rec.code = i_in_type;
    assign w_in_rec.mac  = i_in_mac;

    // request intake
    drf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_action      (i_action),
        .i_unique_only (i_unique_only),
        .i_rec         (w_in_rec),
        .o_full        (full),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    // execution
    drf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ring_mode (r_ring_mode),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // result queue, two deep
    assign w_res_ready = (r_oq_cnt != 2'd2);
    assign w_oq_wr     = w_res_valid && w_res_ready;
    assign empty       = (r_oq_cnt == 2'd0);
    assign w_oq_rd     = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (w_oq_wr) begin
                r_oq_wp <= ~r_oq_wp;
            end
            if (w_oq_rd) begin
                r_oq_rp <= ~r_oq_rp;
            end
            case ({w_oq_wr, w_oq_rd})
                2'b10:   r_oq_cnt <= r_oq_cnt + 2'd1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 2'd1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oq_wr) begin
            r_oq[r_oq_wp] <= w_res;
        end
    end

    // result ports
    assign w_head           = r_oq[r_oq_rp];
    assign o_pop_valid      = w_head.pop_valid;
    assign o_out_ip         = w_head.rec.ip;
    assign o_out_type       = w_head.rec.code;
    assign o_out_mac        = w_head.rec.mac;
    assign o_full_seen      = w_head.full_seen;
    assign o_push_dropped   = w_head.push_dropped;
    assign o_push_duplicate = w_head.push_duplicate;
    assign o_overrun_count  = w_head.overrun;
    assign o_used_count     = w_head.used;

    // checks
    `include "dedup_ring_fifo_unit_defines.svh"

    `DRF_ASSERT_NXT(a_res_lands, i_clk, i_rst_n, w_res_valid && w_res_ready, !empty)
    `DRF_ASSERT_IMP(a_drop_sets_full, i_clk, i_rst_n, !empty && o_push_dropped, o_full_seen)
    `DRF_ASSERT_IMP(a_pop_no_push_flags, i_clk, i_rst_n, !empty && o_pop_valid,
                    !o_push_dropped && !o_push_duplicate)

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking bench for dedup_ring_fifo_unit: directed, overflow, back-pressure and random runs
// every request is predicted in the bench and checked against the popped result
// depends on drf_pkg and the rtl of dedup_ring_fifo_unit
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drf_pkg::*;

    localparam int SLOTS        = DEPTH_DEF;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 80;

    logic              i_clk;
    logic              i_rst_n          = 1'b0;
    logic              push             = 1'b0;
    logic              full;
    logic [1:0]        i_action         = ACT_NONE;
    logic              i_unique_only    = 1'b0;
    logic [31:0]       i_in_ip          = '0;
    logic [15:0]       i_in_type        = '0;
    logic [47:0]       i_in_mac         = '0;
    logic              empty;
    logic              pop              = 1'b0;
    logic              o_pop_valid;
    logic [31:0]       o_out_ip;
    logic [15:0]       o_out_type;
    logic [47:0]       o_out_mac;
    logic              o_full_seen;
    logic              o_push_dropped;
    logic              o_push_duplicate;
    logic [31:0]       o_overrun_count;
    logic [USED_W-1:0] o_used_count;
    logic              i_cfg_valid      = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data       = 1'b0;

    // bench copy of the fifo state and the overflow mode
    t_rec        model_slots [SLOTS];
    int          model_wr       = 0;
    int          model_rd       = 0;
    logic        model_full     = 1'b0;
    logic [31:0] model_overruns = '0;
    logic        model_ring     = 1'b0;

    // predicted results in request order, recent records for duplicate hits
    t_res arp_status_q [$];
    t_rec recent_recs [$];

    int   fail_count = 0;
    logic no_idle    = 1'b0;
    logic hold_req   = 1'b0;

    dedup_ring_fifo_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_unique_only    (i_unique_only),
        .i_in_ip          (i_in_ip),
        .i_in_type        (i_in_type),
        .i_in_mac         (i_in_mac),
        .empty            (empty),
        .pop              (pop),
        .o_pop_valid      (o_pop_valid),
        .o_out_ip         (o_out_ip),
        .o_out_type       (o_out_type),
        .o_out_mac        (o_out_mac),
        .o_full_seen      (o_full_seen),
        .o_push_dropped   (o_push_dropped),
        .o_push_duplicate (o_push_duplicate),
        .o_overrun_count  (o_overrun_count),
        .o_used_count     (o_used_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int next_slot(input int idx);
        return (idx + 1 >= SLOTS) ? 0 : idx + 1;
    endfunction

    // apply one request to the bench state and return the status it reports
    function automatic t_res apply_arp_request(input logic [1:0] act, input logic uq,
                                               input t_rec rec);
        t_res res;
        logic at_full;
        logic seen;
        int   idx;
        res = '0;
        if (act == ACT_PUSH) begin
            at_full = (next_slot(model_wr) == model_rd);
            model_full = at_full;
            if (at_full && model_overruns != 32'hFFFF_FFFF) begin
                model_overruns++;
            end
            // scan only the occupied entries
            seen = 1'b0;
            idx = model_rd;
            while (idx != model_wr) begin
                if (model_slots[idx] == rec) begin
                    seen = 1'b1;
                end
                idx = next_slot(idx);
            end
            if (at_full && !model_ring) begin
                res.push_dropped = 1'b1;
            end else if (uq && seen) begin
                res.push_duplicate = 1'b1;
            end else begin
                model_slots[model_wr] = rec;
                model_wr = next_slot(model_wr);
                // ring mode overwrites the oldest record
                if (at_full) begin
                    model_rd = next_slot(model_rd);
                end
            end
        end else if (act == ACT_POP) begin
            if (model_rd != model_wr) begin
                res.pop_valid = 1'b1;
                res.rec = model_slots[model_rd];
                model_rd = next_slot(model_rd);
            end
        end else if (act == ACT_FLUSH) begin
            model_rd = model_wr;
            model_full = 1'b0;
        end
        res.full_seen = model_full;
        res.overrun   = model_overruns;
        res.used      = USED_W'((model_wr - model_rd + SLOTS) % SLOTS);
        return res;
    endfunction

    // fresh fully random record, remembered for later duplicates
    function automatic t_rec fresh_record();
        t_rec rec;
        rec.ip   = $urandom();
        rec.code = 16'($urandom());
        rec.mac  = {16'($urandom()), $urandom()};
        recent_recs.push_front(rec);
        if (recent_recs.size() > 16) begin
            void'(recent_recs.pop_back());
        end
        return rec;
    endfunction

    // mix of exact repeats, near misses on one field and fresh records
    function automatic t_rec make_record();
        t_rec rec;
        int   roll;
        roll = $urandom_range(0, 99);
        if (recent_recs.size() != 0 && roll < 50) begin
            rec = recent_recs[$urandom_range(0, recent_recs.size() - 1)];
            if (roll >= 30) begin
                case ($urandom_range(0, 2))
                    0: rec.ip = $urandom();
                    1: rec.code = 16'($urandom());
                    default: rec.mac = {16'($urandom()), $urandom()};
                endcase
            end
        end else begin
            rec = fresh_record();
        end
        return rec;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s expected %h actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    // offer one request until accepted, then predict its result
    task automatic send_request(input logic [1:0] act, input logic uq, input t_rec rec);
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_action      <= act;
        i_unique_only <= uq;
        i_in_ip       <= rec.ip;
        i_in_type     <= rec.code;
        i_in_mac      <= rec.mac;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        arp_status_q.push_back(apply_arp_request(act, uq, rec));
    endtask

    task automatic send_random_request(input int push_pct, input int pop_pct);
        logic [1:0] act;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            act = ACT_PUSH;
        end else if (roll < push_pct + pop_pct) begin
            act = ACT_POP;
        end else if (roll[0]) begin
            act = ACT_FLUSH;
        end else begin
            act = ACT_NONE;
        end
        send_request(act, $urandom_range(0, 99) < 60, make_record());
    endtask

    // stop offering and wait until every predicted result has been popped
    task automatic await_all_results();
        int waited;
        waited = 0;
        push <= 1'b0;
        while (arp_status_q.size() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > DRAIN_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    endtask

    // overflow mode is only changed with the block idle
    task automatic set_ring_mode(input logic mode);
        await_all_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        model_ring = mode;
    endtask

    // result checker and receiver throttling
    initial begin
        t_res want;
        int   hold_left;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (arp_status_q.size() == 0) begin
                    $error("result popped with no request pending");
                    fail_count++;
                end else begin
                    want = arp_status_q.pop_front();
                    check_field("pop_valid", 64'(want.pop_valid), 64'(o_pop_valid));
                    check_field("out_ip", 64'(want.rec.ip), 64'(o_out_ip));
                    check_field("out_type", 64'(want.rec.code), 64'(o_out_type));
                    check_field("out_mac", 64'(want.rec.mac), 64'(o_out_mac));
                    check_field("full_seen", 64'(want.full_seen), 64'(o_full_seen));
                    check_field("push_dropped", 64'(want.push_dropped),
                                64'(o_push_dropped));
                    check_field("push_duplicate", 64'(want.push_duplicate),
                                64'(o_push_duplicate));
                    check_field("overrun_count", 64'(want.overrun), 64'(o_overrun_count));
                    check_field("used_count", 64'(want.used), 64'(o_used_count));
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (no_idle) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // field extremes, every action and the duplicate filter on a small fill
    task automatic run_directed_cases();
        t_rec zero_rec;
        t_rec ones_rec;
        t_rec near;
        zero_rec = '0;
        ones_rec = '1;
        send_request(ACT_POP, 1'b0, zero_rec);      // pop on empty
        send_request(ACT_NONE, 1'b1, ones_rec);     // unused action code
        send_request(ACT_FLUSH, 1'b0, zero_rec);
        send_request(ACT_PUSH, 1'b0, zero_rec);
        send_request(ACT_PUSH, 1'b1, ones_rec);
        send_request(ACT_PUSH, 1'b1, ones_rec);     // duplicate skipped
        send_request(ACT_PUSH, 1'b0, ones_rec);     // stored twice without filter
        near = ones_rec;
        near.ip = 32'h0;
        send_request(ACT_PUSH, 1'b1, near);         // only ip differs
        near = ones_rec;
        near.code = 16'h0;
        send_request(ACT_PUSH, 1'b1, near);         // only type differs
        near = ones_rec;
        near.mac = 48'h0;
        send_request(ACT_PUSH, 1'b1, near);         // only mac differs
        send_request(ACT_PUSH, 1'b1, zero_rec);     // duplicate of the oldest
        send_request(ACT_POP, 1'b1, ones_rec);
        send_request(ACT_POP, 1'b0, zero_rec);
        send_request(ACT_PUSH, 1'b1, zero_rec);     // no longer stored, so kept
        send_request(ACT_FLUSH, 1'b1, ones_rec);
        send_request(ACT_POP, 1'b0, ones_rec);      // empty after flush
        send_request(ACT_PUSH, 1'b1, ones_rec);
        send_request(ACT_NONE, 1'b0, zero_rec);
        send_request(ACT_POP, 1'b0, zero_rec);
        send_request(ACT_POP, 1'b0, zero_rec);
    endtask

    // drop mode: fill, overflow, pop keeps the full flag, refill
    task automatic run_drop_overflow();
        t_rec first_rec;
        set_ring_mode(1'b0);
        send_request(ACT_FLUSH, 1'b0, make_record());
        first_rec = fresh_record();
        send_request(ACT_PUSH, 1'b0, first_rec);
        for (int n = 1; n < SLOTS - 1; n++) begin
            send_request(ACT_PUSH, 1'b0, fresh_record());
        end
        for (int n = 0; n < 3; n++) begin
            send_request(ACT_PUSH, n[0], fresh_record());
        end
        send_request(ACT_PUSH, 1'b1, first_rec);    // full beats the filter
        send_request(ACT_POP, 1'b0, make_record()); // full flag left as it was
        send_request(ACT_PUSH, 1'b1, fresh_record());
        send_request(ACT_PUSH, 1'b0, fresh_record());
        send_request(ACT_FLUSH, 1'b0, make_record());
        send_request(ACT_POP, 1'b0, make_record());
    endtask

    // ring mode: overwrite the oldest, duplicate while full, drain past empty
    task automatic run_ring_overflow();
        t_rec first_rec;
        t_rec last_rec;
        set_ring_mode(1'b1);
        send_request(ACT_FLUSH, 1'b0, make_record());
        first_rec = fresh_record();
        send_request(ACT_PUSH, 1'b1, first_rec);
        for (int n = 1; n < SLOTS - 1; n++) begin
            send_request(ACT_PUSH, 1'b0, fresh_record());
        end
        for (int n = 0; n < 6; n++) begin
            last_rec = fresh_record();
            send_request(ACT_PUSH, 1'b1, last_rec);
        end
        send_request(ACT_PUSH, 1'b1, last_rec);     // duplicate while full
        send_request(ACT_PUSH, 1'b1, first_rec);    // overwritten earlier, so kept
        for (int n = 0; n < SLOTS; n++) begin
            send_request(ACT_POP, 1'($urandom_range(0, 1)), make_record());
        end
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic run_full_backpressure();
        hold_req = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_random_request(80, 16);
        end
    endtask

    // a stretch with neither side idling
    task automatic run_unthrottled_burst();
        no_idle = 1'b1;
        for (int n = 0; n < 150; n++) begin
            send_random_request(55, 41);
        end
        no_idle = 1'b0;
    endtask

    // random phases, each with its own overflow mode and fill/drain segments
    task automatic run_random_mix();
        int seg_left;
        int push_pct;
        int pop_pct;
        seg_left = 0;
        push_pct = 50;
        pop_pct  = 46;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                set_ring_mode(phase[0]);
            end else begin
                set_ring_mode(1'($urandom_range(0, 1)));
            end
            for (int n = 0; n < 150; n++) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 80);
                    case ($urandom_range(0, 2))
                        0: begin
                            push_pct = 85;
                            pop_pct  = 11;
                        end
                        1: begin
                            push_pct = 25;
                            pop_pct  = 71;
                        end
                        default: begin
                            push_pct = 50;
                            pop_pct  = 46;
                        end
                    endcase
                end
                seg_left--;
                send_random_request(push_pct, pop_pct);
            end
        end
    endtask

    // reset, test sequence and final verdict
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_ring_mode(1'b0);
        run_directed_cases();
        run_drop_overflow();
        run_ring_overflow();
        run_full_backpressure();
        run_unthrottled_burst();
        run_random_mix();
        await_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && arp_status_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
